// ----- sv/heap_tree_nodes_at_distance_k_assert.svh -----
// Assertion macros used by the checker file.
`ifndef HEAP_TREE_NODES_AT_DISTANCE_K_ASSERT_SVH
`define HEAP_TREE_NODES_AT_DISTANCE_K_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HND_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define HND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/hnd_pkg.sv -----
package hnd_pkg;

  // Storage sizing
  localparam int unsigned MaxNodes  = 64;
  localparam int unsigned ValueBits = 16;
  localparam int unsigned SlotW     = $clog2(MaxNodes);
  localparam int unsigned CntW      = $clog2(MaxNodes + 1);
  localparam int unsigned WordW     = ValueBits + 1;

  // Fixed field widths
  localparam int unsigned OpW    = 2;
  localparam int unsigned FieldW = 16;
  localparam int unsigned DistW  = 4;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // Request to the distance walker
  typedef struct packed {
    logic            start;
    logic [CntW-1:0] a;
    logic [CntW-1:0] b;
    logic [DistW-1:0] k;
  } dist_req_t;

  // Status from the distance walker
  typedef struct packed {
    logic done;
    logic hit;
  } dist_res_t;

endpackage

// ----- sv/hnd_stream_if.sv -----
// Input beat: one command
interface hnd_in_if;
  logic                          valid;
  logic                          ready;
  logic [hnd_pkg::OpW-1:0]       opcode;
  logic [hnd_pkg::FieldW-1:0]    node_value;
  logic                          node_is_null;
  logic [hnd_pkg::FieldW-1:0]    query_value;
  logic [hnd_pkg::DistW-1:0]     query_distance;

  modport source (
    output valid, opcode, node_value, node_is_null, query_value, query_distance,
    input  ready
  );
  modport sink (
    input  valid, opcode, node_value, node_is_null, query_value, query_distance,
    output ready
  );
endinterface

// Output beat: one result
interface hnd_out_if;
  logic                       valid;
  logic                       ready;
  logic [hnd_pkg::FieldW-1:0] result_value;
  logic                       result_valid;
  logic                       last;

  modport source (
    output valid, result_value, result_valid, last,
    input  ready
  );
  modport sink (
    input  valid, result_value, result_valid, last,
    output ready
  );
endinterface

// ----- sv/heap_tree_nodes_at_distance_k.sv -----
// Channel  Dir  Beat contents
// in_i     in   opcode, node_value, node_is_null, query_value, query_distance
// out_o    out  result_value, result_valid, last
//
// Clear and append complete in the idle state and leave the input open.
// A query scans each origin slot and, for an origin that matches, every slot
// as a candidate walked by the distance unit; nulls and
// already emitted slots skip the walk. The single RAM read port sets the scan.
// Reset empties the tree and clears the marks; there is no clearing pass.
// A found result waits in a pending register until the next is known; the scan
// halts while that result must move out and the output register is still full.
module heap_tree_nodes_at_distance_k (
  input  logic      clk_i,
  input  logic      rst_ni,
  hnd_in_if.sink    in_i,
  hnd_out_if.source out_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_ORD  = 8'b00000010,
    S_OCHK = 8'b00000100,
    S_SRD  = 8'b00001000,
    S_SCHK = 8'b00010000,
    S_DIST = 8'b00100000,
    S_EMIT = 8'b01000000,
    S_FIN  = 8'b10000000
  } state_e;

  state_e                          state_q, state_d;
  logic [hnd_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic [hnd_pkg::SlotW-1:0]       o_q, o_d;
  logic [hnd_pkg::SlotW-1:0]       s_q, s_d;
  logic [hnd_pkg::FieldW-1:0]      target_q, target_d;
  logic [hnd_pkg::DistW-1:0]       k_q, k_d;
  logic [hnd_pkg::MaxNodes-1:0]    marks_q;
  logic                            pend_have_q, pend_have_d;
  logic [hnd_pkg::ValueBits-1:0]   pend_val_q, pend_val_d;
  logic [hnd_pkg::ValueBits-1:0]   cand_q, cand_d;
  logic                            out_valid_q;
  logic [hnd_pkg::FieldW-1:0]      out_value_q;
  logic                            out_rvalid_q;
  logic                            out_last_q;

  logic                            in_acc;
  logic                            out_free;
  logic                            last_o;
  logic                            last_s;
  logic                            step_s;
  logic                            marks_clr;
  logic                            marks_set;
  logic                            push;
  logic [hnd_pkg::FieldW-1:0]      push_value;
  logic                            push_rvalid;
  logic                            push_last;

  logic                            ram_we;
  logic [hnd_pkg::SlotW-1:0]       ram_raddr;
  logic [hnd_pkg::WordW-1:0]       ram_wdata;
  logic [hnd_pkg::WordW-1:0]       ram_rdata;
  logic                            rd_null;
  logic [hnd_pkg::ValueBits-1:0]   rd_val;

  hnd_pkg::dist_req_t              dist_req;
  hnd_pkg::dist_res_t              dist_res;

  // Slot store: {null flag, value}
  hnd_ram #(
    .Depth (hnd_pkg::MaxNodes),
    .Width (hnd_pkg::WordW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[hnd_pkg::SlotW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared distance walker
  hnd_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dist_req),
    .res_o  (dist_res)
  );

  assign ram_wdata = {in_i.node_is_null, hnd_pkg::ValueBits'(in_i.node_value)};
  assign ram_raddr = (state_q == S_ORD) ? o_q : s_q;
  assign rd_null   = ram_rdata[hnd_pkg::WordW-1];
  assign rd_val    = ram_rdata[hnd_pkg::ValueBits-1:0];

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign last_o     = ((hnd_pkg::CntW'(o_q) + hnd_pkg::CntW'(1)) == cnt_q);
  assign last_s     = ((hnd_pkg::CntW'(s_q) + hnd_pkg::CntW'(1)) == cnt_q);

  // Heap indices are slot plus one
  always_comb begin
    dist_req.start = (state_q == S_SCHK) && !rd_null && !marks_q[s_q];
    dist_req.a     = hnd_pkg::CntW'(o_q) + hnd_pkg::CntW'(1);
    dist_req.b     = hnd_pkg::CntW'(s_q) + hnd_pkg::CntW'(1);
    dist_req.k     = k_q;
  end

  // Sequence the origin and slot scans
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    o_d         = o_q;
    s_d         = s_q;
    target_d    = target_q;
    k_d         = k_q;
    pend_have_d = pend_have_q;
    pend_val_d  = pend_val_q;
    cand_d      = cand_q;
    ram_we      = 1'b0;
    step_s      = 1'b0;
    marks_clr   = 1'b0;
    marks_set   = 1'b0;
    push        = 1'b0;
    push_value  = '0;
    push_rvalid = 1'b0;
    push_last   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_i.opcode)
            hnd_pkg::OP_CLEAR: begin
              cnt_d = '0;
            end
            hnd_pkg::OP_APPEND: begin
              if (cnt_q < hnd_pkg::CntW'(hnd_pkg::MaxNodes)) begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + hnd_pkg::CntW'(1);
              end
            end
            hnd_pkg::OP_QUERY: begin
              target_d    = in_i.query_value;
              k_d         = in_i.query_distance;
              marks_clr   = 1'b1;
              pend_have_d = 1'b0;
              o_d         = '0;
              state_d     = (cnt_q == '0) ? S_FIN : S_ORD;
            end
            default: begin
            end
          endcase
        end
      end
      S_ORD: begin
        state_d = S_OCHK;
      end
      S_OCHK: begin
        if (!rd_null && (32'(rd_val) == 32'(target_q))) begin
          s_d     = '0;
          state_d = S_SRD;
        end else if (last_o) begin
          state_d = S_FIN;
        end else begin
          o_d     = o_q + hnd_pkg::SlotW'(1);
          state_d = S_ORD;
        end
      end
      S_SRD: begin
        state_d = S_SCHK;
      end
      S_SCHK: begin
        cand_d = rd_val;
        if (rd_null || marks_q[s_q]) begin
          step_s = 1'b1;
        end else begin
          state_d = S_DIST;
        end
      end
      S_DIST: begin
        if (dist_res.done) begin
          if (dist_res.hit) begin
            state_d = S_EMIT;
          end else begin
            step_s = 1'b1;
          end
        end
      end
      S_EMIT: begin
        // Move the held result out, hold the new one until the next is known
        if (!pend_have_q || out_free) begin
          push        = pend_have_q;
          push_value  = hnd_pkg::FieldW'(pend_val_q);
          push_rvalid = 1'b1;
          pend_val_d  = cand_q;
          pend_have_d = 1'b1;
          marks_set   = 1'b1;
          step_s      = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          push        = 1'b1;
          push_value  = pend_have_q ? hnd_pkg::FieldW'(pend_val_q) : '0;
          push_rvalid = pend_have_q;
          push_last   = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Advance to the next slot, or the next origin at the end of a scan
    if (step_s) begin
      if (!last_s) begin
        s_d     = s_q + hnd_pkg::SlotW'(1);
        state_d = S_SRD;
      end else if (last_o) begin
        state_d = S_FIN;
      end else begin
        o_d     = o_q + hnd_pkg::SlotW'(1);
        state_d = S_ORD;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      marks_q     <= '0;
      pend_have_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_have_q <= pend_have_d;
      if (marks_clr) begin
        marks_q <= '0;
      end else if (marks_set) begin
        marks_q[s_q] <= 1'b1;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    o_q        <= o_d;
    s_q        <= s_d;
    target_q   <= target_d;
    k_q        <= k_d;
    pend_val_q <= pend_val_d;
    cand_q     <= cand_d;
    if (push) begin
      out_value_q  <= push_value;
      out_rvalid_q <= push_rvalid;
      out_last_q   <= push_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_value_q;
  assign out_o.result_valid = out_rvalid_q;
  assign out_o.last         = out_last_q;

endmodule

// ----- sv/hnd_ram.sv -----
module hnd_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 17,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/hnd_dist.sv -----
module hnd_dist (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hnd_pkg::dist_req_t req_i,
  output hnd_pkg::dist_res_t res_o
);

  logic                        busy_q;
  logic [hnd_pkg::CntW-1:0]    a_q;
  logic [hnd_pkg::CntW-1:0]    b_q;
  logic [hnd_pkg::DistW-1:0]   k_q;
  logic [hnd_pkg::DistW-1:0]   d_q;
  logic                        same;
  logic                        at_k;

  // Stop on meeting at the common ancestor or when the walked distance reaches k
  always_comb begin
    same       = (a_q == b_q);
    at_k       = (d_q == k_q);
    res_o.done = busy_q && (same || at_k);
    res_o.hit  = busy_q && same && at_k;
  end

  // Track the walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (res_o.done) begin
      busy_q <= 1'b0;
    end
  end

  // Step the larger index up to its parent, one edge a cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
      k_q <= req_i.k;
      d_q <= '0;
    end else if (busy_q && !res_o.done) begin
      if (a_q > b_q) begin
        a_q <= a_q >> 1;
      end else begin
        b_q <= b_q >> 1;
      end
      d_q <= d_q + hnd_pkg::DistW'(1);
    end
  end

endmodule

// ----- sv/hnd_checker.sv -----
`include "heap_tree_nodes_at_distance_k_assert.svh"

module hnd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [hnd_pkg::OpW-1:0]     in_opcode_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [hnd_pkg::FieldW-1:0]  out_value_i,
  input logic                        out_rvalid_i,
  input logic                        out_last_i
);

  // Hold a stalled result beat
  `HND_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_value_i) && $stable(out_rvalid_i) && $stable(out_last_i))

  // An empty answer closes its query
  `HND_ASSERT_NOW(a_empty_last, clk_i, rst_ni, out_valid_i && !out_rvalid_i, out_last_i)

  // An empty answer carries a zero value
  `HND_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, out_valid_i && !out_rvalid_i, out_value_i == '0)

  // An accepted query leaves the input closed once it starts
  `HND_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_valid_i && in_ready_i && (in_opcode_i == hnd_pkg::OP_QUERY), !in_ready_i)

endmodule

bind heap_tree_nodes_at_distance_k hnd_checker u_hnd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_opcode_i  (in_i.opcode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_value_i  (out_o.result_value),
  .out_rvalid_i (out_o.result_valid),
  .out_last_i   (out_o.last)
);
